// ----- hdl/utf16_to_utf8_encoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_unit_macros
// assertion helpers shared by the encoder top level
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_ENCODER_UNIT_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define U16U8_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// types, constants and byte encoding helpers of the utf-16 to utf-8 encoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // surrogate tags in the top six bits of a code unit
  localparam logic [5:0] HIGH_SURR_TAG = 6'h36;
  localparam logic [5:0] LOW_SURR_TAG  = 6'h37;
  // offset added to a joined surrogate pair
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // input beat
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_string;
  } out_item_t;

  // length class of the main encoding
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ONE,
    KIND_TWO,
    KIND_THREE,
    KIND_FOUR
  } kind_t;

  // classified job passed from front to back
  typedef struct packed {
    logic        pre_valid;
    logic [9:0]  pre_bits;
    kind_t       kind;
    logic [20:0] value;
    logic        last;
  } job_t;

  // number of bytes of a length class
  function automatic logic [2:0] kind_len(input kind_t kind);
    logic [2:0] len;
    case (kind)
      KIND_ONE:   len = 3'd1;
      KIND_TWO:   len = 3'd2;
      KIND_THREE: len = 3'd3;
      KIND_FOUR:  len = 3'd4;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  // byte at position pos of an encoding
  function automatic logic [7:0] enc_byte(input kind_t kind, input logic [20:0] v,
                                          input logic [1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    case (kind)
      KIND_ONE: b = {1'b0, v[6:0]};
      KIND_TWO: begin
        if (pos == 2'd0) b = {3'b110, v[10:6]};
        else             b = {2'b10, v[5:0]};
      end
      KIND_THREE: begin
        case (pos)
          2'd0:    b = {4'b1110, v[15:12]};
          2'd1:    b = {2'b10, v[11:6]};
          default: b = {2'b10, v[5:0]};
        endcase
      end
      KIND_FOUR: begin
        case (pos)
          2'd0:    b = {5'b11110, v[20:18]};
          2'd1:    b = {2'b10, v[17:12]};
          2'd2:    b = {2'b10, v[11:6]};
          default: b = {2'b10, v[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/u16u8_front.sv -----
// ----------------------------------------------------------------------------
// u16u8_front
// accepts code units, pairs surrogates and classifies each unit into a job
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u16u8_pkg::in_item_t in_data,
  input  logic                q_full,
  output logic                q_push,
  output u16u8_pkg::job_t     q_job
);
  import u16u8_pkg::*;

  logic        have_high_r, have_high_nxt;
  logic [9:0]  high_bits_r, high_bits_nxt;
  logic        accept;
  logic        is_low, is_high;
  logic [15:0] cu;
  job_t        job;

  assign accept  = push && !q_full;
  assign cu      = in_data.code_unit;
  assign is_low  = (cu[15:10] == LOW_SURR_TAG);
  assign is_high = (cu[15:10] == HIGH_SURR_TAG);

  // classification and surrogate holding
  always_comb begin
    have_high_nxt = have_high_r;
    high_bits_nxt = high_bits_r;
    job.pre_valid = 1'b0;
    job.pre_bits  = high_bits_r;
    job.kind      = KIND_NONE;
    job.value     = {5'd0, cu};
    job.last      = in_data.last_unit;
    if (have_high_r && is_low) begin
      job.kind      = KIND_FOUR;
      job.value     = {1'b0, high_bits_r, cu[9:0]} + SUPP_BASE;
      have_high_nxt = 1'b0;
    end else begin
      job.pre_valid = have_high_r;
      have_high_nxt = 1'b0;
      if (cu[15:7] == 9'd0) begin
        job.kind = KIND_ONE;
      end else if (cu[15:11] == 5'd0) begin
        job.kind = KIND_TWO;
      end else if (is_high && !in_data.last_unit) begin
        job.kind      = KIND_NONE;
        have_high_nxt = 1'b1;
        high_bits_nxt = cu[9:0];
      end else begin
        job.kind = KIND_THREE;
      end
    end
  end

  // a unit that is only held produces no job
  assign q_push = accept && (job.pre_valid || (job.kind != KIND_NONE));
  assign q_job  = job;

  // held surrogate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_high_r <= 1'b0;
      high_bits_r <= 10'd0;
    end else if (accept) begin
      have_high_r <= have_high_nxt;
      high_bits_r <= high_bits_nxt;
    end
  end

endmodule

// ----- hdl/u16u8_queue.sv -----
// ----------------------------------------------------------------------------
// u16u8_queue
// short register queue of jobs between front and back
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t din,
  output logic            full,
  input  logic            pop,
  output u16u8_pkg::job_t dout,
  output logic            empty
);
  import u16u8_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- hdl/u16u8_back.sv -----
// ----------------------------------------------------------------------------
// u16u8_back
// serialises each job into utf-8 bytes through an output register
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  u16u8_pkg::job_t      q_job,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output u16u8_pkg::out_item_t out_data
);
  import u16u8_pkg::*;

  job_t      cur_r, cur_nxt;
  logic      cur_valid_r, cur_valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic [2:0] cur_len;
  logic [2:0] main_idx;
  logic      last_byte, emit, done;
  logic [7:0] byte_val;

  // byte count of the current job and position in it
  assign cur_len   = (cur_r.pre_valid ? 3'd3 : 3'd0) + kind_len(cur_r.kind);
  assign last_byte = (idx_r == cur_len - 3'd1);
  assign emit      = cur_valid_r && (!out_valid_r || pop);
  assign done      = emit && last_byte;
  assign q_pop     = !q_empty && (!cur_valid_r || done);
  assign main_idx  = cur_r.pre_valid ? idx_r - 3'd3 : idx_r;

  // byte selection: held lone surrogate first, then the main encoding
  always_comb begin
    if (cur_r.pre_valid && (idx_r < 3'd3)) begin
      byte_val = enc_byte(KIND_THREE, {5'd0, HIGH_SURR_TAG, cur_r.pre_bits}, idx_r[1:0]);
    end else begin
      byte_val = enc_byte(cur_r.kind, cur_r.value, main_idx[1:0]);
    end
  end

  // job and output register next values
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_nxt.out_byte      = byte_val;
      out_nxt.last_of_item  = last_byte;
      out_nxt.end_of_string = last_byte && cur_r.last;
      out_valid_nxt         = 1'b1;
      idx_nxt               = idx_r + 3'd1;
    end
    if (done) begin
      cur_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_nxt       = q_job;
      cur_valid_nxt = 1'b1;
      idx_nxt       = 3'd0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

endmodule

// ----- hdl/utf16_to_utf8_encoder_unit.sv -----
// path: queue entry, serialiser job register, then output register for each byte
// throughput: one byte per cycle from the byte serialiser while the receiver pops,
// and 1 to 6 bytes a job (1 ascii, 2 or 3 other bmp, 4 pair, plus 3 for a flushed surrogate)
// a held high surrogate produces nothing until the next unit arrives
// reset: synchronous active-low rst_n clears queue, held surrogate and output register
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_unit
// utf-16 code unit stream in, utf-8 byte stream out
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_encoder_unit_macros.svh"

module utf16_to_utf8_encoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  u16u8_pkg::in_item_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output u16u8_pkg::out_item_t out_data
);
  import u16u8_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  job_t q_din, q_dout;

  // classification front
  u16u8_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_din)
  );

  // job queue
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // byte serialiser
  u16u8_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (q_dout),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  assign full = q_full;

  // checks
  `U16U8_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full, "job pushed into full queue")
  `U16U8_ASSERT_IMPL(a_no_pop_when_empty, q_pop, !q_empty, "job taken from empty queue")
  `U16U8_ASSERT_IMPL(a_eos_on_last, !empty && out_data.end_of_string,
                     out_data.last_of_item, "end of string on a non-final byte")
  `U16U8_ASSERT_NEXT(a_full_blocks, push && full && !pop && empty, !empty || full || q_empty,
                     "queue drained without a byte reaching the output")

endmodule

// ----- tb/tb_utf16_to_utf8_encoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_encoder_unit
// The encoder is fed UTF-16 code units through its push/full port, and every
// UTF-8 byte it pops out is checked against a local encoder model, or against
// the bytes typed into its row. A short directed table opens the run; some
// rows carry their bytes typed in. The directed part covers range edges,
// surrogate pairs, lone and flushed surrogates and a six-byte step. Random
// units follow, mostly plain text and surrogate pairs. The sender works in
// bursts and the receiver stalls on patterns of its own. There are two long
// receiver hold-offs that fill the block and pauses that let every byte drain.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_encoder_unit;
  import u16u8_pkg::*;

  localparam int N_DIRECTED  = 25;
  localparam int UNITS_TOTAL = 460;
  localparam int HOLD_CYCLES = 120;
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 16;

  // random unit classes
  typedef enum logic [2:0] {
    UNIT_ASCII,
    UNIT_TWO,
    UNIT_BMP,
    UNIT_HIGH,
    UNIT_LOW,
    UNIT_ANY
  } unit_class_t;

  // receiver stall patterns
  typedef enum logic [2:0] {
    POP_ALWAYS,
    POP_HALF,
    POP_THREE_IN_FOUR,
    POP_MOSTLY,
    POP_RARE
  } pop_mode_t;

  // directed row: bytes left-aligned, first byte in the top eight bits
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        typed;
    logic [2:0]  n;
    logic [47:0] bytes;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_0000_0000_00},
    '{16'h007F, 1'b1, 1'b1, 3'd1, 48'h7F_0000_0000_00},
    '{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC280_0000_0000},
    '{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDFBF_0000_0000},
    '{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0A080_000000},
    '{16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEFBFBF_000000},
    '{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hEDB080_000000},
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h000000_000000},
    '{16'hDC00, 1'b1, 1'b1, 3'd4, 48'hF0908080_0000},
    '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h000000_000000},
    '{16'hDFFF, 1'b0, 1'b1, 3'd4, 48'hF48FBFBF_0000},
    '{16'hDBFF, 1'b1, 1'b1, 3'd3, 48'hEDAFBF_000000},
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h000000_000000},
    '{16'h0041, 1'b0, 1'b1, 3'd4, 48'hEDA08041_0000},
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h000000_000000},
    '{16'h0800, 1'b1, 1'b1, 3'd6, 48'hEDA080_E0A080},
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h000000_000000},
    '{16'hDBFF, 1'b1, 1'b1, 3'd6, 48'hEDA080_EDAFBF},
    '{16'hD7FF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hE000, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hDFFF, 1'b1, 1'b0, 3'd0, 48'h0},
    '{16'hDB00, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hD8FF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hDE5A, 1'b1, 1'b0, 3'd0, 48'h0},
    '{16'h5555, 1'b0, 1'b0, 3'd0, 48'h0}
  };

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      push  = 1'b0;
  logic      pop   = 1'b0;
  in_item_t  in_data = '0;
  logic      full;
  logic      empty;
  out_item_t out_data;

  // bytes still owed by the block, oldest first
  out_item_t utf8_due [$];
  // bytes produced by the model for the current unit
  out_item_t step_bytes [$];

  // model state
  logic       held_high = 1'b0;
  logic [9:0] held_bits = '0;

  int units_sent      = 0;
  int pairs_joined    = 0;
  int lone_surrogates = 0;
  int bytes_checked   = 0;
  int mismatches      = 0;

  // sender and receiver pacing
  int        burst_left   = 0;
  int        gapless_left = 0;
  logic      hold_req     = 1'b0;
  logic      hold_seen    = 1'b0;
  int        stall_left   = 0;
  int        recv_cycle   = 0;
  pop_mode_t recv_mode    = POP_ALWAYS;
  out_item_t want;

  utf16_to_utf8_encoder_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model: append one byte
  function automatic void add_byte(input logic [7:0] b);
    out_item_t item;
    item.out_byte      = b;
    item.last_of_item  = 1'b0;
    item.end_of_string = 1'b0;
    step_bytes.push_back(item);
  endfunction

  // model: three-byte form of a 16-bit value
  function automatic void add_three(input logic [15:0] v);
    add_byte({4'b1110, v[15:12]});
    add_byte({2'b10, v[11:6]});
    add_byte({2'b10, v[5:0]});
  endfunction

  // model: encode one code unit, update held surrogate state
  function automatic void predict_unit(input in_item_t u);
    logic        is_high;
    logic        is_low;
    logic [20:0] cp;
    out_item_t   tail;
    step_bytes.delete();
    is_high = (u.code_unit[15:10] == HIGH_SURR_TAG);
    is_low  = (u.code_unit[15:10] == LOW_SURR_TAG);
    if (held_high && is_low) begin
      cp = {1'b0, held_bits, u.code_unit[9:0]} + SUPP_BASE;
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
      held_high = 1'b0;
      held_bits = '0;
      pairs_joined++;
    end else begin
      // a held surrogate with no partner goes out on its own
      if (held_high) begin
        add_three({HIGH_SURR_TAG, held_bits});
        held_high = 1'b0;
        held_bits = '0;
        lone_surrogates++;
      end
      if (u.code_unit < 16'h0080) begin
        add_byte({1'b0, u.code_unit[6:0]});
      end else if (u.code_unit < 16'h0800) begin
        add_byte({3'b110, u.code_unit[10:6]});
        add_byte({2'b10, u.code_unit[5:0]});
      end else if (is_high && !u.last_unit) begin
        held_high = 1'b1;
        held_bits = u.code_unit[9:0];
      end else begin
        add_three(u.code_unit);
        if (is_high || is_low) lone_surrogates++;
      end
    end
    // flags ride on the final byte of the step
    if (step_bytes.size() > 0) begin
      tail = step_bytes.pop_back();
      tail.last_of_item  = 1'b1;
      tail.end_of_string = u.last_unit;
      step_bytes.push_back(tail);
    end
  endfunction

  function automatic logic [15:0] rnd16(input int unsigned lo, input int unsigned hi);
    logic [31:0] r;
    r = $urandom_range(hi, lo);
    return r[15:0];
  endfunction

  function automatic logic [15:0] pick_unit(input unit_class_t cls);
    logic [15:0] v;
    case (cls)
      UNIT_ASCII: v = rnd16(16'h0000, 16'h007F);
      UNIT_TWO:   v = rnd16(16'h0080, 16'h07FF);
      UNIT_BMP: begin
        if ($urandom_range(0, 1) == 0) v = rnd16(16'h0800, 16'hD7FF);
        else                           v = rnd16(16'hE000, 16'hFFFF);
      end
      UNIT_HIGH:  v = rnd16(16'hD800, 16'hDBFF);
      UNIT_LOW:   v = rnd16(16'hDC00, 16'hDFFF);
      default:    v = rnd16(16'h0000, 16'hFFFF);
    endcase
    return v;
  endfunction

  function automatic void note_mismatch(input string what, input out_item_t exp_b,
                                        input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %02h/%0b/%0b got %02h/%0b/%0b", $time, what,
               exp_b.out_byte, exp_b.last_of_item, exp_b.end_of_string,
               got.out_byte, got.last_of_item, got.end_of_string);
  endfunction

  // offer one unit, wait for its beat, then queue the bytes it owes
  task automatic send_unit(input in_item_t unit, input logic typed, input logic [2:0] n_typed,
                           input logic [47:0] typed_bytes);
    int        gap;
    out_item_t b;
    if (gapless_left > 0) begin
      gapless_left--;
    end else if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push    <= 1'b1;
    in_data <= unit;
    do @(posedge clk); while (full);
    if (burst_left > 0) burst_left--;
    units_sent++;
    predict_unit(unit);
    if (typed) begin
      for (int k = 0; k < n_typed; k++) begin
        b.out_byte      = typed_bytes[47 - 8*k -: 8];
        b.last_of_item  = (k == n_typed - 1);
        b.end_of_string = (k == n_typed - 1) && unit.last_unit;
        utf8_due.push_back(b);
      end
    end else begin
      foreach (step_bytes[k]) utf8_due.push_back(step_bytes[k]);
    end
  endtask

  task automatic send_class(input unit_class_t cls, input logic may_end);
    in_item_t u;
    u.code_unit = pick_unit(cls);
    u.last_unit = may_end && ($urandom_range(0, 7) == 0);
    send_unit(u, 1'b0, 3'd0, 48'h0);
  endtask

  // sender stops until every owed byte has been taken
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (utf8_due.size() != 0);
  endtask

  // receiver: check each popped beat, then choose the next pop
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        bytes_checked++;
        if (utf8_due.size() == 0) begin
          note_mismatch("byte with nothing pending", '0, out_data);
        end else begin
          want = utf8_due.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.last_of_item !== want.last_of_item ||
              out_data.end_of_string !== want.end_of_string)
            note_mismatch("byte mismatch", want, out_data);
        end
      end
      recv_cycle++;
      if (recv_cycle % 48 == 0) recv_mode = pop_mode_t'($urandom_range(0, 4));
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        stall_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        case (recv_mode)
          POP_ALWAYS:        pop <= 1'b1;
          POP_HALF:          pop <= ($urandom_range(0, 1) == 0);
          POP_THREE_IN_FOUR: pop <= (recv_cycle % 4 != 0);
          POP_MOSTLY:        pop <= ($urandom_range(0, 9) != 0);
          default:           pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else                                    idle_cycles++;
    end
    $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // stimulus
  initial begin
    dir_row_t row;
    in_item_t u;
    int       pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      u.code_unit = row.unit;
      u.last_unit = row.last;
      send_unit(u, row.typed, row.n, row.bytes);
    end
    drain_results();

    // random units, mostly well-formed pairs and plain bmp text
    for (int i = 0; units_sent < UNITS_TOTAL; i++) begin
      if (i == 40 || i == 200) begin
        hold_req <= ~hold_req;
        gapless_left = 40;
      end
      if (i == 120) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        send_class(UNIT_ASCII, 1'b1);
      end else if (pick < 36) begin
        send_class(UNIT_TWO, 1'b1);
      end else if (pick < 50) begin
        send_class(UNIT_BMP, 1'b1);
      end else if (pick < 70) begin
        send_class(UNIT_HIGH, $urandom_range(0, 1) == 0);
        send_class(UNIT_LOW, 1'b1);
      end else if (pick < 80) begin
        // held surrogate broken by a non-low unit
        send_class(UNIT_HIGH, 1'b0);
        send_class(unit_class_t'($urandom_range(0, 3)), 1'b1);
      end else if (pick < 88) begin
        send_class(UNIT_LOW, 1'b1);
      end else begin
        send_class(UNIT_ANY, 1'b1);
      end
    end

    // let the last bytes out
    push <= 1'b0;
    do @(posedge clk); while (utf8_due.size() != 0);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d code units (%0d directed), %0d joined pairs, %0d lone surrogates",
             units_sent, N_DIRECTED, pairs_joined, lone_surrogates);
    $display("%0d utf-8 bytes checked, %0d mismatches", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
